// ===== design/tspg_pkg.sv =====
// Package for the three-axis step pulse generator: field widths, request and
// register codes, and the per-axis status struct. No dependencies.
package tspg_pkg;

  localparam int PERIOD_W    = 16;
  localparam int COUNT_W     = 32;
  localparam int AXIS_W      = 2;
  localparam int NUM_PERIODS = 3;
  localparam int OUT_AXES    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Request kinds carried on in_tuser.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t REG_AXIS0_PERIOD = 2'd0;
  localparam cfg_idx_t REG_AXIS1_PERIOD = 2'd1;
  localparam cfg_idx_t REG_AXIS2_PERIOD = 2'd2;

  // Status of one axis for the beat being accepted.
  typedef struct packed {
    logic step;         // axis steps on this tick
    logic finish;       // axis reaches a zero count on this tick
    logic zero_old;     // remaining count is zero before this beat
    logic zero_new;     // remaining count is zero after this beat
    logic running_new;  // run flag after this beat
  } lane_status_t;

endpackage

// ===== design/tspg_axis.sv =====
// One axis of the step pulse generator: run flag, remaining count and tick
// counter, with the step decision for a tick. Depends on tspg_pkg.
module tspg_axis (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick_en,
  input  logic                   start_en,
  input  tspg_pkg::count_t       start_count,
  input  tspg_pkg::period_t      period,
  output tspg_pkg::lane_status_t status
);
  import tspg_pkg::*;

  logic    running_r, running_nxt;
  count_t  steps_r, steps_nxt;
  period_t tick_r, tick_nxt;

  logic    active;
  logic    fire;
  count_t  steps_dec;

  // A count of all ones parks the axis: armed but never stepping.
  assign active    = running_r && (steps_r != '1);
  assign fire      = tick_en && active && (tick_r >= period);
  assign steps_dec = steps_r - count_t'(1);

  always_comb begin
    running_nxt = running_r;
    steps_nxt   = steps_r;
    tick_nxt    = tick_r;
    if (start_en) begin
      running_nxt = 1'b1;
      steps_nxt   = start_count;
    end else if (tick_en && active) begin
      if (fire) begin
        // Counter restarts at zero and then counts this tick.
        tick_nxt  = period_t'(1);
        steps_nxt = steps_dec;
        if (steps_dec == '0) begin
          running_nxt = 1'b0;
        end
      end else begin
        tick_nxt = tick_r + period_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      steps_r   <= '0;
      tick_r    <= '0;
    end else begin
      running_r <= running_nxt;
      steps_r   <= steps_nxt;
      tick_r    <= tick_nxt;
    end
  end

  always_comb begin
    status.step        = fire;
    status.finish      = fire && (steps_dec == '0);
    status.zero_old    = (steps_r == '0);
    status.zero_new    = (steps_nxt == '0);
    status.running_new = running_nxt;
  end

endmodule

// ===== design/three_axis_step_pulse_generator_core.sv =====
// Top level of the three-axis step pulse generator: configuration registers,
// one lane per axis, move-done logic and a two-entry output buffer.
// Depends on tspg_pkg and tspg_axis.
//
// Use: program the period of each axis through the configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block is idle; cfg_ready
// is always high and a write to an unused index is dropped. Each input beat is
// either a tick (in_tuser low) or a start (in_tuser high) that arms the axis in
// in_tdata with the step count in in_tdata. A start with a zero count, or on an
// axis the block does not have, changes nothing.
// Every input beat yields exactly one output beat carrying the per-axis step
// pulses, the move-done flag and the per-axis run flags after the beat.
// One beat is accepted every cycle while in_tready is high: all lane updates
// are a compare and a decrement per axis in the accepting cycle, and the state
// holds only across beats.
// The output side has a main register plus a skid register, so a beat is still
// taken in the cycle the receiver first stalls; in_tready falls only when both
// are full and rises again as soon as the receiver takes a beat.
// Synchronous reset clears all axis state, the periods and both buffer entries.
module three_axis_step_pulse_generator_core #(
  parameter int AXES = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // in_tdata, lowest bit up: axis[1:0], step_count[33:2], zero pad [39:34]
  input  logic [tspg_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: req_type (0 = tick, 1 = start)
  input  logic                                  in_tuser,
  // Result channel.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_tdata, lowest bit up: step_pulse[2:0], move_done[3], running[6:4],
  // zero pad [7]
  output logic [tspg_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Configuration channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  tspg_pkg::cfg_idx_t                    cfg_index,
  input  tspg_pkg::period_t                     cfg_data
);
  import tspg_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration: one period register per axis; axes past the third share
  // the third period.
  // ---------------------------------------------------------------------------
  period_t periods_r [NUM_PERIODS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PERIODS; p++) begin
        periods_r[p] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AXIS0_PERIOD: periods_r[0] <= cfg_data;
        REG_AXIS1_PERIOD: periods_r[1] <= cfg_data;
        REG_AXIS2_PERIOD: periods_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input beat decode.
  // ---------------------------------------------------------------------------
  logic [AXIS_W-1:0] in_axis;
  count_t            in_count;
  logic              in_fire;
  logic              tick_en;
  logic              start_ok;

  assign in_axis  = in_tdata[AXIS_W-1:0];
  assign in_count = in_tdata[AXIS_W +: COUNT_W];
  assign in_fire  = in_tvalid && in_tready;
  assign tick_en  = in_fire && (in_tuser == REQ_TICK);
  assign start_ok = in_fire && (in_tuser == REQ_START) && (in_count != '0);

  // ---------------------------------------------------------------------------
  // Axis lanes.
  // ---------------------------------------------------------------------------
  lane_status_t lane_st [AXES];

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    localparam int PIDX = (g < NUM_PERIODS) ? g : NUM_PERIODS - 1;

    tspg_axis u_axis (
      .clk         (clk),
      .rst_n       (rst_n),
      .tick_en     (tick_en),
      .start_en    (start_ok && (int'(in_axis) == g)),
      .start_count (in_count),
      .period      (periods_r[PIDX]),
      .status      (lane_st[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Move done. Axes are handled in order on a tick, so when axis i finishes
  // the all-zero check sees the updated counts of the axes before it and the
  // not yet updated counts of the axes after it.
  // ---------------------------------------------------------------------------
  logic         done_w;
  logic         all_zero_new;
  logic [OUT_AXES-1:0] pulse_w;
  logic [OUT_AXES-1:0] run_w;

  always_comb begin
    logic ok;
    done_w       = 1'b0;
    all_zero_new = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      ok = lane_st[i].finish;
      for (int j = 0; j < AXES; j++) begin
        if (j < i) begin
          ok = ok && lane_st[j].zero_new;
        end else if (j > i) begin
          ok = ok && lane_st[j].zero_old;
        end
      end
      done_w       = done_w || ok;
      all_zero_new = all_zero_new && lane_st[i].zero_new;
    end
  end

  // Only the first three axes are reported.
  always_comb begin
    pulse_w = '0;
    run_w   = '0;
    for (int k = 0; k < OUT_AXES; k++) begin
      if (k < AXES) begin
        pulse_w[k] = lane_st[k].step;
        run_w[k]   = lane_st[k].running_new;
      end
    end
  end

  logic [OUT_TDATA_W-1:0] result_w;
  assign result_w = OUT_TDATA_W'({run_w, done_w, pulse_w});

  // ---------------------------------------------------------------------------
  // Output buffer: main register drives the port, the skid register catches
  // the beat accepted in the cycle the receiver stalls.
  // ---------------------------------------------------------------------------
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_data_nxt  = result_w;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a held main entry.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while main entry empty");

  // Back-pressure on the input only comes from a full buffer.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !$past(out_tready) || skid_valid_r))
    else $error("input stalled with buffer space free");

  // A start beat never steps an axis nor reports a finished move.
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == REQ_START)) |-> ((pulse_w == '0) && !done_w))
    else $error("step or move done on a start beat");

  // A finished move leaves every count at zero.
  a_done_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done_w |-> all_zero_new)
    else $error("move done with a count still outstanding");

  // After an accepted beat, out_tvalid is high on the next cycle.
  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted beat lost");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for three_axis_step_pulse_generator_core: directed and random
// tick/start beats, with the period registers reprogrammed between phases.
// Depends on tspg_pkg and the core; results are checked against an in-bench step predictor.
module tb_top;
  import tspg_pkg::*;

  // Axis code that the block does not have; a start on it must change nothing.
  localparam logic [AXIS_W-1:0] ABSENT_AXIS = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;

  // One result beat, as the predictor expects it.
  typedef struct packed {
    logic [2:0] step_pulse;
    logic       move_done;
    logic [2:0] running;
  } step_result_t;

  // Scoreboard: it mirrors the axis state, predicts the result of every accepted
  // input beat and checks each result beat against the oldest prediction.
  class step_scoreboard;
    period_t      axis_period[3];
    logic         armed[3];
    count_t       steps_left[3];
    period_t      tick_count[3];
    step_result_t pending[$];
    int           errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        axis_period[i] = '0;
        armed[i] = 1'b0;
        steps_left[i] = '0;
        tick_count[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_period(int idx, period_t value);
      axis_period[idx] = value;
    endfunction

    function bit counts_all_zero();
      for (int i = 0; i < 3; i++) begin
        if (steps_left[i] != '0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(logic req, logic [AXIS_W-1:0] ax, count_t cnt);
      step_result_t res;
      res = '0;
      if (req == REQ_START) begin
        // A zero count or a missing axis leaves everything as it was; the tick
        // counter is kept even when a running axis is re-armed.
        if (ax != ABSENT_AXIS && cnt != '0) begin
          armed[ax] = 1'b1;
          steps_left[ax] = cnt;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          // An all-ones count parks the axis: armed, but it neither steps nor counts.
          if (armed[i] && steps_left[i] != '1) begin
            if (tick_count[i] >= axis_period[i]) begin
              res.step_pulse[i] = 1'b1;
              tick_count[i] = '0;
              steps_left[i] = steps_left[i] - 1'b1;
              if (steps_left[i] == '0) begin
                armed[i] = 1'b0;
                // Later axes are still seen with their counts from before this tick.
                if (counts_all_zero()) res.move_done = 1'b1;
              end
            end
            tick_count[i] = tick_count[i] + 1'b1;
          end
        end
      end
      for (int i = 0; i < 3; i++) res.running[i] = armed[i];
      pending.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      step_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing outstanding", $time, beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (beat[2:0] !== want.step_pulse) begin
        $display("%0t: step_pulse expected %b, got %b", $time, want.step_pulse, beat[2:0]);
        errors++;
      end
      if (beat[3] !== want.move_done) begin
        $display("%0t: move_done expected %b, got %b", $time, want.move_done, beat[3]);
        errors++;
      end
      if (beat[6:4] !== want.running) begin
        $display("%0t: running expected %b, got %b", $time, want.running, beat[6:4]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // axis[1:0], step_count[33:2], zero pad [39:34]
  logic                   in_tuser;   // req_type (0 = tick, 1 = start)
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // step_pulse[2:0], move_done[3], running[6:4], pad [7]
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index;
  period_t                cfg_data;

  step_scoreboard sb;
  // While calm is set neither side idles, which gives the block a long stretch
  // of back-to-back beats with the receiver always ready.
  bit calm;
  int stall_cycles;

  three_axis_step_pulse_generator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Unless the phase is calm, the receiver stalls in roughly 31 percent of cycles.
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // Every accepted result beat is checked at the edge on which it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: the run is abandoned once stall_cycles reaches STALL_LIMIT with no
  // beat moving on any channel. Legitimate pauses come from sender gaps,
  // receiver stalls and the drain settle time, so the limit is generous.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offers one input beat and holds it until the block takes it. The valid stays
  // high afterwards unless a random gap follows, so the next call never lowers
  // and raises it within the same time step. Outside calm phases a short gap
  // follows roughly 31 beats of a hundred.
  task automatic send_beat(logic req, logic [AXIS_W-1:0] ax, count_t cnt);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {6'b0, cnt, ax};
    do @(posedge clk); while (!in_tready);
    sb.note_input(req, ax, cnt);
    if (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic tick();
    send_beat(REQ_TICK, '0, '0);
  endtask

  task automatic start(logic [AXIS_W-1:0] ax, count_t cnt);
    send_beat(REQ_START, ax, cnt);
  endtask

  // Stops offering beats and waits until every predicted result has been taken,
  // then for a further settle period so that nothing is left in flight in the block.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three period registers back to back; only called while idle.
  task automatic write_periods(period_t p0, period_t p1, period_t p2);
    cfg_idx_t regs[3] = '{REG_AXIS0_PERIOD, REG_AXIS1_PERIOD, REG_AXIS2_PERIOD};
    period_t  vals[3];
    vals = '{p0, p1, p2};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_period(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly short periods so that steps and finishes are frequent, with the odd
  // maximum or fully random value that mostly keeps an axis from stepping.
  function automatic period_t pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 40) return period_t'($urandom_range(0, 2));
    if (r < 90) return period_t'($urandom_range(3, 8));
    if (r < 95) return '1;
    return period_t'($urandom_range(0, 65535));
  endfunction

  // One random beat: about a quarter are starts, mostly with small counts so
  // that moves complete, plus zero, all-ones and wide random counts and the odd
  // start on the missing axis.
  task automatic random_beat();
    int                  r;
    logic [AXIS_W-1:0]   ax;
    count_t              cnt;
    r = $urandom_range(99);
    if (r < 28) begin
      ax = ($urandom_range(9) == 0) ? ABSENT_AXIS : AXIS_W'($urandom_range(0, 2));
      r = $urandom_range(99);
      if (r < 70) cnt = count_t'($urandom_range(1, 12));
      else if (r < 80) cnt = '0;
      else if (r < 87) cnt = '1;
      else cnt = count_t'($urandom());
      start(ax, cnt);
    end else begin
      tick();
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    stall_cycles = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= REQ_TICK;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_AXIS0_PERIOD;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A tick with nothing armed, then three axes started with
    // different periods so that some finish on the same tick.
    write_periods('0, 16'd1, 16'd2);
    tick();
    start(2'd0, 32'd1);
    start(2'd1, 32'd2);
    start(2'd2, 32'd1);
    repeat (4) tick();
    // Starts that must be ignored: the missing axis and a zero count.
    start(ABSENT_AXIS, 32'd5);
    start(2'd0, '0);
    // A parked axis with an all-ones count, and a re-arm that replaces a count.
    start(2'd2, '1);
    start(2'd0, 32'd3);
    start(2'd0, 32'd1);
    start(2'd1, 32'h8000_0002);
    start(2'd1, 32'd2);
    repeat (3) tick();
    drain();

    // Longest periods: tick counters climb but nothing steps.
    write_periods('1, '1, '1);
    start(2'd0, 32'd4);
    start(2'd1, 32'd2);
    repeat (3) tick();
    drain();

    // Periods dropped below the counters: the next tick steps at once. Then the
    // parked axis gets a finite count and the move completes.
    write_periods('0, '0, '0);
    repeat (2) tick();
    start(2'd2, 32'd1);
    repeat (3) tick();
    drain();

    // Random part: five phases of a hundred beats, each with fresh periods; the
    // middle phase runs with no idling on either side.
    for (int phase = 0; phase < 5; phase++) begin
      calm = (phase == 2);
      write_periods(pick_period(), pick_period(), pick_period());
      repeat (100) random_beat();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tspg_pkg.sv
design/tspg_axis.sv
design/three_axis_step_pulse_generator_core.sv
bench/tb_top.sv
